@@ hdl/mvsm_pkg.sv @@
// Package for the multi-voice stereo sample mixer.
// Holds operation and status codes, sequencer states and shared types.
package mvsm_pkg;

  typedef enum logic [2:0] {
    OP_WRITE = 3'd0,
    OP_OPEN  = 3'd1,
    OP_CLOSE = 3'd2,
    OP_PLAY  = 3'd3,
    OP_STOP  = 3'd4,
    OP_GAIN  = 3'd5,
    OP_MIX   = 3'd6,
    OP_NONE  = 3'd7
  } op_t;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_NO_SLOT  = 2'd1;
  localparam logic [1:0] ST_INACTIVE = 2'd2;

  localparam logic [15:0] UNITY_GAIN = 16'd32768;
  localparam logic signed [19:0] OUT_MAX = 20'sd32767;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DECODE,
    S_VOICE,
    S_RD_L,
    S_RD_R,
    S_MUL1_L,
    S_MUL2_L,
    S_MUL1_R,
    S_MUL2_R,
    S_ACC,
    S_DONE
  } state_t;

  // Request to the multiply unit: x * g, held product.
  typedef struct packed {
    logic               start;
    logic signed [33:0] a;
    logic        [15:0] b;
  } mul_req_t;

endpackage

@@ hdl/mvsm_mul.sv @@
// Shared signed-by-unsigned multiplier with a registered product.
// Depends on mvsm_pkg.
module mvsm_mul
  import mvsm_pkg::*;
(
  input  logic               clk,
  input  mul_req_t           req,
  output logic signed [50:0] prod
);

  always_ff @(posedge clk) begin
    if (req.start) begin
      prod <= req.a * $signed({1'b0, req.b});
    end
  end

endmodule

@@ hdl/mvsm_mem.sv @@
// Sample memory: one write port, one registered read port.
// Depends on nothing beyond its parameters.
module mvsm_mem #(
  parameter int DEPTH = 65536
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [15:0]              wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [15:0]              rdata
);

  logic [15:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ hdl/multi_voice_stereo_sample_mixer.sv @@
// Top level of the multi-voice stereo sample mixer.
// Uses mvsm_pkg, mvsm_mem and mvsm_mul.
//
// channel   dir  fields
// s_axis    in   item: operation .. voice_gain_right (tdata)
// m_axis    out  result: status, granted_slot, mix_left, mix_right
// cfg       in   master_gain_left (0), master_gain_right (1)
//
// An item passes idle (accept), decode and result when nothing stalls. A mix item
// adds one visit per voice: S_VOICE through S_ACC for a playing voice with samples
// left, S_VOICE only otherwise; the single shared multiplier and the one memory read
// port set this. Reset (rst) clears the active and loop flags, sets the paused flags
// and the master gains to unity; voice fields and sample memory are not cleared.
// s_axis_tready is low while an item is in work or its result waits on m_axis.
module multi_voice_stereo_sample_mixer
  import mvsm_pkg::*;
#(
  parameter int NUM_VOICES       = 16,
  parameter int SAMPLE_MEM_DEPTH = 65536
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // operation[2:0] voice_slot[6:3] mem_address[22:7] sample_value[38:23]
  // source_length[55:39] restart[56] repeat_req[57] voice_gain_left[73:58]
  // voice_gain_right[89:74], zero fill to 96
  input  logic [95:0] s_axis_tdata,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // status[1:0] granted_slot[5:2] mix_left[21:6] mix_right[37:22], zero to 40
  output logic [39:0] m_axis_tdata,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [15:0] cfg_data
);

  localparam int VW = (NUM_VOICES > 1) ? $clog2(NUM_VOICES) : 1;
  localparam int AW = $clog2(SAMPLE_MEM_DEPTH);

  state_t state, state_next;

  logic [15:0] master_l, master_r;

  logic [2:0]  in_op;
  logic [3:0]  in_slot;
  logic [15:0] in_addr, in_sval, in_gl, in_gr;
  logic [16:0] in_len;
  logic        in_restart, in_rep;

  logic [NUM_VOICES-1:0] v_active, v_paused, v_loop;
  logic [15:0] v_base [NUM_VOICES];
  logic [16:0] v_len  [NUM_VOICES];
  logic [16:0] v_pos  [NUM_VOICES];
  logic [16:0] v_rem  [NUM_VOICES];
  logic [15:0] v_gl   [NUM_VOICES];
  logic [15:0] v_gr   [NUM_VOICES];

  logic [VW-1:0]     vidx;
  logic              vlast;
  logic signed [23:0] acc_l, acc_r;
  logic signed [15:0] smp_l, smp_r;
  logic [1:0]  res_status;
  logic [3:0]  res_slot;
  logic signed [15:0] res_l, res_r;

  logic          free_found;
  logic [VW-1:0] free_idx;
  logic          slot_ok;
  logic [VW-1:0] sidx;

  logic          mem_we;
  logic [AW-1:0] mem_raddr;
  logic [15:0]   mem_rdata;
  mul_req_t      mreq;
  logic signed [50:0] mprod;
  logic signed [50:0] prod_hold;
  logic signed [23:0] scaled;

  assign s_axis_tready = (state == S_IDLE);

  always_ff @(posedge clk) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_op      <= s_axis_tdata[2:0];
      in_slot    <= s_axis_tdata[6:3];
      in_addr    <= s_axis_tdata[22:7];
      in_sval    <= s_axis_tdata[38:23];
      in_len     <= s_axis_tdata[55:39];
      in_restart <= s_axis_tdata[56];
      in_rep     <= s_axis_tdata[57];
      in_gl      <= s_axis_tdata[73:58];
      in_gr      <= s_axis_tdata[89:74];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      master_l <= UNITY_GAIN;
      master_r <= UNITY_GAIN;
    end else if (cfg_we) begin
      if (cfg_index) master_r <= cfg_data;
      else           master_l <= cfg_data;
    end
  end

  always_comb begin
    free_found = 1'b0;
    free_idx   = '0;
    for (int i = NUM_VOICES - 1; i >= 0; i--) begin
      if (!v_active[i]) begin
        free_found = 1'b1;
        free_idx   = VW'(i);
      end
    end
  end

  assign sidx    = VW'(in_slot);
  assign slot_ok = (32'(in_slot) < NUM_VOICES) && v_active[sidx];
  assign vlast   = (32'(vidx) == NUM_VOICES - 1);

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE:   if (s_axis_tvalid) state_next = S_DECODE;
      S_DECODE: state_next = (op_t'(in_op) == OP_MIX) ? S_VOICE : S_DONE;
      S_VOICE: begin
        if (v_active[vidx] && !v_paused[vidx] && v_rem[vidx] != '0) begin
          state_next = S_RD_L;
        end else if (vlast) begin
          state_next = S_DONE;
        end
      end
      S_RD_L:   state_next = S_RD_R;
      S_RD_R:   state_next = S_MUL1_L;
      S_MUL1_L: state_next = S_MUL2_L;
      S_MUL2_L: state_next = S_MUL1_R;
      S_MUL1_R: state_next = S_MUL2_R;
      S_MUL2_R: state_next = S_ACC;
      S_ACC:    state_next = vlast ? S_DONE : S_VOICE;
      S_DONE:   if (m_axis_tready) state_next = S_IDLE;
      default:  state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else     state <= state_next;
  end

  always_comb begin
    mem_raddr = AW'(v_base[vidx] + v_pos[vidx][15:0]);
    if (state == S_RD_L) mem_raddr = AW'(v_base[vidx] + v_pos[vidx][15:0] + 16'd1);
  end

  assign mem_we = (state == S_DECODE) && (op_t'(in_op) == OP_WRITE);

  mvsm_mem #(.DEPTH(SAMPLE_MEM_DEPTH)) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (AW'(in_addr)),
    .wdata (in_sval),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  always_comb begin
    mreq.start = 1'b0;
    mreq.a     = '0;
    mreq.b     = '0;
    unique case (state)
      S_MUL1_L: begin
        mreq.start = 1'b1;
        mreq.a     = 34'(smp_l);
        mreq.b     = master_l;
      end
      S_MUL2_L: begin
        mreq.start = 1'b1;
        mreq.a     = 34'(mprod);
        mreq.b     = v_gl[vidx];
      end
      S_MUL1_R: begin
        mreq.start = 1'b1;
        mreq.a     = 34'(smp_r);
        mreq.b     = master_r;
      end
      S_MUL2_R: begin
        mreq.start = 1'b1;
        mreq.a     = 34'(mprod);
        mreq.b     = v_gr[vidx];
      end
      default: ;
    endcase
  end

  mvsm_mul u_mul (
    .clk  (clk),
    .req  (mreq),
    .prod (mprod)
  );

  // arithmetic shift floors the scaled product
  assign scaled = 24'(mprod >>> 30);

  always_ff @(posedge clk) begin
    unique case (state)
      S_RD_L:   smp_l <= mem_rdata;
      S_RD_R:   smp_r <= mem_rdata;
      S_MUL1_R: prod_hold <= mprod;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v_active <= '0;
      v_paused <= '1;
      v_loop   <= '0;
    end else if (state == S_DECODE) begin
      unique case (op_t'(in_op))
        OP_OPEN: if (free_found) begin
          v_active[free_idx] <= 1'b1;
          v_paused[free_idx] <= 1'b1;
          v_loop[free_idx]   <= 1'b0;
        end
        OP_CLOSE: if (slot_ok) v_active[sidx] <= 1'b0;
        OP_PLAY: if (slot_ok) begin
          v_paused[sidx] <= 1'b0;
          if (in_rep) v_loop[sidx] <= 1'b1;
        end
        OP_STOP: if (slot_ok) v_paused[sidx] <= 1'b1;
        default: ;
      endcase
    end else if (state == S_VOICE) begin
      if (v_active[vidx] && !v_paused[vidx] && v_rem[vidx] == '0 && !v_loop[vidx]) begin
        v_paused[vidx] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_DECODE) begin
      unique case (op_t'(in_op))
        OP_OPEN: if (free_found) begin
          v_base[free_idx] <= in_addr;
          v_len[free_idx]  <= in_len;
          v_pos[free_idx]  <= '0;
          v_rem[free_idx]  <= in_len;
          v_gl[free_idx]   <= UNITY_GAIN;
          v_gr[free_idx]   <= UNITY_GAIN;
        end
        OP_PLAY: if (slot_ok && in_restart) begin
          v_pos[sidx] <= '0;
          v_rem[sidx] <= v_len[sidx];
        end
        OP_GAIN: if (slot_ok) begin
          v_gl[sidx] <= in_gl;
          v_gr[sidx] <= in_gr;
        end
        default: ;
      endcase
    end else if (state == S_VOICE) begin
      if (v_active[vidx] && !v_paused[vidx] && v_rem[vidx] == '0 && v_loop[vidx]) begin
        v_pos[vidx] <= '0;
        v_rem[vidx] <= v_len[vidx];
      end
    end else if (state == S_ACC) begin
      v_pos[vidx] <= v_pos[vidx] + 17'd2;
      v_rem[vidx] <= (v_rem[vidx] >= 17'd2) ? v_rem[vidx] - 17'd2 : '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vidx <= '0;
    end else if (state == S_DECODE) begin
      vidx <= '0;
    end else if ((state == S_VOICE && state_next != S_RD_L && !vlast) ||
                 (state == S_ACC && !vlast)) begin
      vidx <= vidx + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_DECODE) begin
      acc_l <= '0;
      acc_r <= '0;
    end else if (state == S_ACC) begin
      acc_l <= acc_l + 24'(prod_hold >>> 30);
      acc_r <= acc_r + scaled;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_DECODE) begin
      res_status <= ST_OK;
      res_slot   <= '0;
      unique case (op_t'(in_op))
        OP_OPEN: begin
          if (free_found) res_slot <= 4'(free_idx);
          else            res_status <= ST_NO_SLOT;
        end
        OP_CLOSE, OP_PLAY, OP_STOP, OP_GAIN: if (!slot_ok) res_status <= ST_INACTIVE;
        default: ;
      endcase
    end
  end

  always_comb begin
    res_l = '0;
    res_r = '0;
    if (op_t'(in_op) == OP_MIX) begin
      if (acc_l > OUT_MAX)       res_l = 16'sd32767;
      else if (acc_l < -OUT_MAX) res_l = -16'sd32767;
      else                       res_l = 16'(acc_l);
      if (acc_r > OUT_MAX)       res_r = 16'sd32767;
      else if (acc_r < -OUT_MAX) res_r = -16'sd32767;
      else                       res_r = 16'(acc_r);
    end
  end

  assign m_axis_tvalid = (state == S_DONE);
  assign m_axis_tdata  = {2'b00, res_r, res_l, res_slot, res_status};

  a_ready_idle: assert property (@(posedge clk) disable iff (rst)
    s_axis_tready |-> !m_axis_tvalid) else $error("ready while result pending");
  a_hold_result: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result dropped");
  a_accept_decode: assert property (@(posedge clk) disable iff (rst)
    s_axis_tvalid && s_axis_tready |=> state == S_DECODE)
    else $error("accept not decoded");

endmodule
